>>> hdl/clru_pkg.sv
`default_nettype none
package clru_pkg;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CAP_BITS = 7;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;
   localparam logic REG_CAPACITY = 1'b0;

   typedef enum logic [1:0] {
      MODE_MAP    = 2'd0,
      MODE_ACCESS = 2'd1,
      MODE_TICK   = 2'd2,
      MODE_EVICT  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_REVOKE = 2'd0,
      KIND_VICTIM = 2'd1,
      KIND_EMPTY  = 2'd2,
      KIND_FULL   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_PART,
      ST_DRAIN,
      ST_FULL,
      ST_EMPTY,
      ST_EVICT
   } state_type;

   typedef enum logic [1:0] {
      WALK_NONE,
      WALK_ACCESS,
      WALK_PART,
      WALK_DRAIN
   } walk_type;

   typedef struct packed {
      logic     latch_req;
      logic     map_write;
      logic     walk_clear;
      logic     walk_restart;
      walk_type walk;
      logic     evict_read;
      logic     load_full;
      logic     load_empty;
      logic     load_victim;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic walk_done;
      logic drain_none;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

>>> hdl/clru_if.sv
`default_nettype none
interface clru_req_if #(
   parameter int PAGE_BITS = 20
);
   logic                 valid;
   logic                 ready;
   logic [1:0]           mode;
   logic [PAGE_BITS-1:0] page_number;

   modport source (output valid, output mode, output page_number, input ready);
   modport sink (input valid, input mode, input page_number, output ready);
endinterface

interface clru_rsp_if #(
   parameter int PAGE_BITS = 20
);
   logic                 valid;
   logic                 ready;
   logic [PAGE_BITS-1:0] page_out;
   logic [1:0]           kind;
   logic                 last;

   modport source (output valid, output page_out, output kind, output last, input ready);
   modport sink (input valid, input page_out, input kind, input last, output ready);
endinterface
`default_nettype wire

>>> hdl/clru_ctrl.sv
`default_nettype none
module clru_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   input  wire clru_pkg::mode_type req_mode,
   input  wire clru_pkg::status_type status,
   output logic                   req_ready,
   output clru_pkg::cmd_type      cmd
);

   clru_pkg::state_type state_ff;
   clru_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= clru_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_ready = 1'b0;
      cmd = '0;
      cmd.walk = clru_pkg::WALK_NONE;
      unique case (state_ff)
         clru_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               cmd.walk_clear = 1'b1;
               unique case (req_mode)
                  clru_pkg::MODE_MAP: begin
                     if (status.full) begin
                        state_in = clru_pkg::ST_FULL;
                     end else begin
                        cmd.map_write = 1'b1;
                     end
                  end
                  clru_pkg::MODE_ACCESS: begin
                     if (!status.empty) begin
                        state_in = clru_pkg::ST_ACCESS;
                     end
                  end
                  clru_pkg::MODE_TICK: begin
                     if (!status.empty) begin
                        state_in = clru_pkg::ST_PART;
                     end
                  end
                  clru_pkg::MODE_EVICT: begin
                     if (status.empty) begin
                        state_in = clru_pkg::ST_EMPTY;
                     end else begin
                        cmd.evict_read = 1'b1;
                        state_in = clru_pkg::ST_EVICT;
                     end
                  end
               endcase
            end
         end
         clru_pkg::ST_ACCESS: begin
            cmd.walk = clru_pkg::WALK_ACCESS;
            if (status.walk_done) begin
               state_in = clru_pkg::ST_IDLE;
            end
         end
         clru_pkg::ST_PART: begin
            cmd.walk = clru_pkg::WALK_PART;
            if (status.walk_done) begin
               if (status.drain_none) begin
                  state_in = clru_pkg::ST_IDLE;
               end else begin
                  cmd.walk_restart = 1'b1;
                  state_in = clru_pkg::ST_DRAIN;
               end
            end
         end
         clru_pkg::ST_DRAIN: begin
            cmd.walk = clru_pkg::WALK_DRAIN;
            if (status.walk_done) begin
               state_in = clru_pkg::ST_IDLE;
            end
         end
         clru_pkg::ST_FULL: begin
            if (status.out_free) begin
               cmd.load_full = 1'b1;
               state_in = clru_pkg::ST_IDLE;
            end
         end
         clru_pkg::ST_EMPTY: begin
            if (status.out_free) begin
               cmd.load_empty = 1'b1;
               state_in = clru_pkg::ST_IDLE;
            end
         end
         clru_pkg::ST_EVICT: begin
            if (status.out_free) begin
               cmd.load_victim = 1'b1;
               state_in = clru_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = clru_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> hdl/clru_dpath.sv
`default_nettype none
module clru_dpath #(
   parameter int QUEUE_DEPTH = 64,
   parameter int PAGE_BITS = 20
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire clru_pkg::cmd_type               cmd,
   input  wire [PAGE_BITS-1:0]                  req_page,
   input  wire                                  csr_psel,
   input  wire                                  csr_penable,
   input  wire                                  csr_pwrite,
   input  wire [clru_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  wire [clru_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [clru_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   input  wire                                  rsp_ready,
   output logic                                 rsp_valid,
   output logic [PAGE_BITS-1:0]                 rsp_page,
   output logic [1:0]                           rsp_kind,
   output logic                                 rsp_last,
   output clru_pkg::status_type                 status
);

   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int CMPW = (CW > clru_pkg::CAP_BITS) ? CW : clru_pkg::CAP_BITS;
   localparam logic [IW-1:0] LAST_SLOT = IW'(QUEUE_DEPTH - 1);

   logic [PAGE_BITS:0]   main_mem [QUEUE_DEPTH];
   logic [PAGE_BITS-1:0] temp_mem [QUEUE_DEPTH];

   logic [PAGE_BITS:0]   main_rd_ff;
   logic [PAGE_BITS-1:0] temp_rd_ff;
   logic                 main_we;
   logic [IW-1:0]        main_waddr;
   logic [PAGE_BITS:0]   main_wdata;
   logic                 main_re;
   logic [IW-1:0]        main_raddr;
   logic                 temp_we;
   logic [IW-1:0]        temp_waddr;
   logic                 temp_re;

   logic [clru_pkg::CAP_BITS-1:0] capacity_ff;
   logic [IW-1:0]        head_ff, head_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic                 sv_ff, sv_in;
   logic [CW-1:0]        nf_ff, nf_in;
   logic [IW-1:0]        rd_slot_ff, rd_slot_in;
   logic [IW-1:0]        w_slot_ff, w_slot_in;
   logic [IW-1:0]        addr_q_ff, addr_q_in;
   logic [PAGE_BITS-1:0] req_page_ff, req_page_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PAGE_BITS-1:0] rsp_page_ff, rsp_page_in;
   clru_pkg::kind_type   rsp_kind_ff, rsp_kind_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 csr_write;
   logic [CMPW-1:0]      eff_cap;
   logic [CW:0]          tail_sum;
   logic [CW:0]          tail_wrap;
   logic [IW-1:0]        tail;
   logic                 out_free;
   logic                 issue;
   logic                 main_rd_flag;
   logic [PAGE_BITS-1:0] main_rd_page;

   assign main_rd_flag = main_rd_ff[PAGE_BITS];
   assign main_rd_page = main_rd_ff[PAGE_BITS-1:0];

   assign csr_write = csr_psel && csr_penable && csr_pwrite
                      && (csr_paddr[2] == clru_pkg::REG_CAPACITY);
   assign csr_prdata = (csr_paddr[2] == clru_pkg::REG_CAPACITY)
                       ? {{(clru_pkg::CSR_DATA_BITS - clru_pkg::CAP_BITS){1'b0}}, capacity_ff}
                       : '0;

   assign eff_cap = (CMPW'(capacity_ff) > CMPW'(QUEUE_DEPTH))
                    ? CMPW'(QUEUE_DEPTH) : CMPW'(capacity_ff);

   assign tail_sum = (CW + 1)'(head_ff) + (CW + 1)'(count_ff);
   assign tail_wrap = (tail_sum >= (CW + 1)'(QUEUE_DEPTH))
                      ? tail_sum - (CW + 1)'(QUEUE_DEPTH) : tail_sum;
   assign tail = tail_wrap[IW-1:0];

   assign out_free = !rsp_valid_ff || rsp_ready;

   assign status.full = (CMPW'(count_ff) >= eff_cap);
   assign status.empty = (count_ff == '0);
   assign status.drain_none = (nf_ff == '0);
   assign status.out_free = out_free;
   assign status.walk_done = !sv_ff && ((cmd.walk == clru_pkg::WALK_DRAIN)
                             ? (idx_ff == nf_ff) : (idx_ff == count_ff));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_page = rsp_page_ff;
   assign rsp_kind = rsp_kind_ff;
   assign rsp_last = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (main_we) begin
         main_mem[main_waddr] <= main_wdata;
      end
      if (main_re) begin
         main_rd_ff <= main_mem[main_raddr];
      end
      if (temp_we) begin
         temp_mem[temp_waddr] <= main_rd_page;
      end
      if (temp_re) begin
         temp_rd_ff <= temp_mem[idx_ff[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= clru_pkg::CAP_RESET;
         head_ff <= '0;
         count_ff <= '0;
         idx_ff <= '0;
         sv_ff <= 1'b0;
         nf_ff <= '0;
         rd_slot_ff <= '0;
         w_slot_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            capacity_ff <= csr_pwdata[clru_pkg::CAP_BITS-1:0];
         end
         head_ff <= head_in;
         count_ff <= count_in;
         idx_ff <= idx_in;
         sv_ff <= sv_in;
         nf_ff <= nf_in;
         rd_slot_ff <= rd_slot_in;
         w_slot_ff <= w_slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_q_ff <= addr_q_in;
      req_page_ff <= req_page_in;
      rsp_page_ff <= rsp_page_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      head_in = head_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      sv_in = sv_ff;
      nf_in = nf_ff;
      rd_slot_in = rd_slot_ff;
      w_slot_in = w_slot_ff;
      addr_q_in = addr_q_ff;
      req_page_in = req_page_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_page_in = rsp_page_ff;
      rsp_kind_in = rsp_kind_ff;
      rsp_last_in = rsp_last_ff;
      main_we = 1'b0;
      main_waddr = w_slot_ff;
      main_wdata = {1'b0, main_rd_page};
      main_re = 1'b0;
      main_raddr = rd_slot_ff;
      temp_we = 1'b0;
      temp_waddr = nf_ff[IW-1:0];
      temp_re = 1'b0;
      issue = 1'b0;

      if (cmd.latch_req) begin
         req_page_in = req_page;
      end

      if (cmd.map_write) begin
         main_we = 1'b1;
         main_waddr = tail;
         main_wdata = {1'b0, req_page};
         count_in = count_ff + CW'(1);
      end

      unique case (cmd.walk)
         clru_pkg::WALK_NONE: begin
            sv_in = 1'b0;
         end
         clru_pkg::WALK_ACCESS, clru_pkg::WALK_PART: begin
            issue = (idx_ff < count_ff);
            sv_in = issue;
            if (issue) begin
               main_re = 1'b1;
               idx_in = idx_ff + CW'(1);
               addr_q_in = rd_slot_ff;
               rd_slot_in = (rd_slot_ff == LAST_SLOT) ? '0 : rd_slot_ff + IW'(1);
            end
            if (sv_ff) begin
               if (cmd.walk == clru_pkg::WALK_ACCESS) begin
                  if (main_rd_page == req_page_ff) begin
                     main_we = 1'b1;
                     main_waddr = addr_q_ff;
                     main_wdata = {1'b1, main_rd_page};
                  end
               end else if (main_rd_flag) begin
                  temp_we = 1'b1;
                  nf_in = nf_ff + CW'(1);
               end else begin
                  main_we = 1'b1;
                  w_slot_in = (w_slot_ff == LAST_SLOT) ? '0 : w_slot_ff + IW'(1);
               end
            end
         end
         clru_pkg::WALK_DRAIN: begin
            issue = (!sv_ff || out_free) && (idx_ff < nf_ff);
            sv_in = issue || (sv_ff && !out_free);
            if (issue) begin
               temp_re = 1'b1;
               idx_in = idx_ff + CW'(1);
            end
            if (sv_ff && out_free) begin
               main_we = 1'b1;
               main_wdata = {1'b0, temp_rd_ff};
               w_slot_in = (w_slot_ff == LAST_SLOT) ? '0 : w_slot_ff + IW'(1);
               rsp_valid_in = 1'b1;
               rsp_page_in = temp_rd_ff;
               rsp_kind_in = clru_pkg::KIND_REVOKE;
               rsp_last_in = (idx_ff == nf_ff);
            end
         end
      endcase

      if (cmd.evict_read) begin
         main_re = 1'b1;
         main_raddr = head_ff;
      end

      if (cmd.load_full) begin
         rsp_valid_in = 1'b1;
         rsp_page_in = req_page_ff;
         rsp_kind_in = clru_pkg::KIND_FULL;
         rsp_last_in = 1'b1;
      end

      if (cmd.load_empty) begin
         rsp_valid_in = 1'b1;
         rsp_page_in = '0;
         rsp_kind_in = clru_pkg::KIND_EMPTY;
         rsp_last_in = 1'b1;
      end

      if (cmd.load_victim) begin
         rsp_valid_in = 1'b1;
         rsp_page_in = main_rd_page;
         rsp_kind_in = clru_pkg::KIND_VICTIM;
         rsp_last_in = 1'b1;
         head_in = (head_ff == LAST_SLOT) ? '0 : head_ff + IW'(1);
         count_in = count_ff - CW'(1);
      end

      if (cmd.walk_clear) begin
         idx_in = '0;
         sv_in = 1'b0;
         nf_in = '0;
         rd_slot_in = head_ff;
         w_slot_in = head_ff;
      end

      if (cmd.walk_restart) begin
         idx_in = '0;
         sv_in = 1'b0;
      end
   end

endmodule
`default_nettype wire

>>> hdl/clru_page_replacement_queue.sv
// Map: taken with no result; the next request is taken in the following cycle.
// Map on full and evict: the result is registered once the output is free; input reopens with it.
// Access: one resident entry per cycle on the main store port.
// Tick: a pass over the entries, then a drain pass when any entry is flagged; revokes
// leave one per cycle from the copy store while the output is not stalled.
// Reset: synchronous; queue empties, capacity returns to 64, no clearing pass.
`default_nettype none
module clru_page_replacement_queue #(
   parameter int QUEUE_DEPTH = 64,
   parameter int PAGE_BITS = 20
) (
   input  wire                                clock,
   input  wire                                reset,
   clru_req_if.sink                           req_if,
   clru_rsp_if.source                         rsp_if,
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire [clru_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire [clru_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [clru_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);

   clru_pkg::cmd_type    cmd;
   clru_pkg::status_type status;
   clru_pkg::mode_type   req_mode;

   assign csr_pready = 1'b1;
   assign req_mode = clru_pkg::mode_type'(req_if.mode);

   clru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_mode  (req_mode),
      .status    (status),
      .req_ready (req_if.ready),
      .cmd       (cmd)
   );

   clru_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .PAGE_BITS   (PAGE_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_page    (req_if.page_number),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .rsp_ready   (rsp_if.ready),
      .rsp_valid   (rsp_if.valid),
      .rsp_page    (rsp_if.page_out),
      .rsp_kind    (rsp_if.kind),
      .rsp_last    (rsp_if.last),
      .status      (status)
   );

   a_idle_no_walk: assert property (@(posedge clock) disable iff (reset)
      req_if.ready |-> (cmd.walk == clru_pkg::WALK_NONE))
      else $error("walk command while taking requests");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_full || cmd.load_empty || cmd.load_victim) |-> status.out_free)
      else $error("result loaded over a waiting result");

   a_map_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.map_write |-> !status.full)
      else $error("map written into a full queue");

   a_evict_blocks: assert property (@(posedge clock) disable iff (reset)
      cmd.evict_read |=> !req_if.ready)
      else $error("request taken before victim delivered");

endmodule
`default_nettype wire
